// File: rtl/crs_pkg.sv
package crs_pkg;

	localparam int COORD_W = 20;
	localparam int DIFF_W  = 21;
	localparam int SQ_W    = 42;
	localparam int LEN_W   = 21;
	localparam int PH_W    = 16;
	localparam int TOT_W   = 22;
	localparam int DIV_N_W = 42;
	localparam int DIV_Q_W = 21;
	localparam int DIV_C_W = 5;
	localparam int T_W     = 16;
	localparam int W_W     = 18;
	localparam int ACC_W   = 42;
	localparam int SQRT_STEPS = SQ_W / 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic                      final_point;
	} pt_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] sz;
		logic                      run_end;
		logic                      clipped;
	} smp_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		point_t p0;
		point_t p1;
		point_t p2;
		point_t p3;
		logic   curved;
		logic   straight;
		logic   fin;
	} cmd_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_LOAD,
		B_SQ,
		B_SQRT,
		B_PLAN,
		B_SAMPLE,
		B_SMUL,
		B_SDIVGO,
		B_SDIV,
		B_SFIN,
		B_TDIV,
		B_WMUL,
		B_WSUM,
		B_MAC,
		B_CSAT,
		B_EMIT,
		B_NEXT,
		B_FLUSH
	} back_state_t;

	function automatic logic signed [COORD_W-1:0] pick_axis(point_t p, logic [1:0] ax);
		logic signed [COORD_W-1:0] r;
		case (ax)
			2'd0: r = p.x;
			2'd1: r = p.y;
			default: r = p.z;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/crs_front.sv
module crs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pt_valid,
	output logic              pt_stall,
	input  crs_pkg::pt_item_t pt,
	input  logic              q_full,
	output logic              q_push,
	output crs_pkg::cmd_t     q_entry
);

	crs_pkg::point_t h0_q, h1_q, h2_q;
	logic [1:0]      seen_q;
	crs_pkg::point_t cur;
	logic            accept;
	logic            need;

	assign cur.x    = pt.px;
	assign cur.y    = pt.py;
	assign cur.z    = pt.pz;
	assign pt_stall = q_full;
	assign accept   = pt_valid && !q_full;

	always_comb begin
		need = 1'b0;
		q_entry.p0 = h2_q;
		q_entry.p1 = h1_q;
		q_entry.p2 = h0_q;
		q_entry.p3 = cur;
		q_entry.fin = pt.final_point;
		q_entry.curved = 1'b0;
		q_entry.straight = 1'b0;
		case (seen_q)
			2'd0: need = 1'b0;
			2'd1: begin
				need = 1'b1;
				q_entry.straight = 1'b1;
			end
			2'd2: begin
				need = pt.final_point;
				q_entry.straight = 1'b1;
			end
			default: begin
				need = 1'b1;
				q_entry.curved = 1'b1;
				q_entry.straight = pt.final_point;
			end
		endcase
	end

	assign q_push = accept && need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q <= '0;
			h1_q <= '0;
			h2_q <= '0;
			seen_q <= 2'd0;
		end else if (accept) begin
			if (pt.final_point) begin
				h0_q <= '0;
				h1_q <= '0;
				h2_q <= '0;
				seen_q <= 2'd0;
			end else begin
				h2_q <= h1_q;
				h1_q <= h0_q;
				h0_q <= cur;
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

// File: rtl/crs_queue.sv
module crs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  crs_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output crs_pkg::cmd_t rdata
);

	crs_pkg::cmd_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/crs_div.sv
module crs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [crs_pkg::DIV_N_W-1:0]   dividend,
	input  logic [crs_pkg::DIV_Q_W-1:0]   divisor,
	output logic                          done,
	output logic [crs_pkg::DIV_Q_W-1:0]   quotient
);

	localparam int QW = crs_pkg::DIV_Q_W;

	logic                        busy_q, done_q;
	logic [crs_pkg::DIV_C_W-1:0] cnt_q;
	logic [QW-1:0]               rem_q, qs_q;
	logic [QW:0]                 trial;
	logic                        ge;

	assign trial    = {rem_q, qs_q[QW-1]};
	assign ge       = (trial >= {1'b0, divisor});
	assign done     = done_q;
	assign quotient = qs_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[crs_pkg::DIV_N_W-1:QW];
			qs_q <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? QW'(trial - {1'b0, divisor}) : trial[QW-1:0];
			qs_q <= {qs_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == crs_pkg::DIV_C_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/crs_back.sv
module crs_back #(
	parameter int MAX_SEG_SAMPLES = 32,
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  crs_pkg::cmd_t      q_head,
	output logic               q_pop,
	output logic               smp_valid,
	input  logic               smp_stall,
	output crs_pkg::smp_item_t smp
);

	localparam int KW   = $clog2(MAX_SEG_SAMPLES + 1);
	localparam int CW   = crs_pkg::COORD_W;
	localparam int DW   = crs_pkg::DIFF_W;
	localparam int LW   = crs_pkg::LEN_W;
	localparam int PW   = crs_pkg::PH_W;
	localparam int TW   = crs_pkg::TOT_W;
	localparam int WW   = crs_pkg::W_W;
	localparam int AW   = crs_pkg::ACC_W;
	localparam int UNIT = 1 << COORD_FRAC_BITS;

	crs_pkg::back_state_t state_q, state_d;

	crs_pkg::cmd_t           cmd_q;
	logic                    seg_curved_q;
	crs_pkg::point_t         a_q;
	logic signed [DW-1:0]    d_q [3];
	logic [1:0]              ax_q;
	logic [1:0]              j_q;
	logic [2:0]              m_q;
	logic [crs_pkg::SQ_W-1:0] sv_q;
	logic [LW+1:0]           rem_q;
	logic [LW-1:0]           root_q;
	logic [crs_pkg::DIV_C_W-1:0] it_q;
	logic [LW-1:0]           len_q;
	logic [PW-1:0]           phase_q, ph_seg_q;
	logic [KW-1:0]           keep_q, k_q;
	logic                    clip_q;
	logic [LW-1:0]           s_q;
	logic signed [DW+LW:0]   prod_q;
	logic signed [CW-1:0]    v_q [3];
	logic [crs_pkg::T_W-1:0] t_q;
	logic [crs_pkg::T_W:0]   r_q;
	logic [31:0]             t2_q;
	logic [47:0]             t3_q;
	logic [33:0]             r2_q;
	logic [WW-1:0]           wa_q, wb_q, w1_q, w2_q;
	logic signed [AW-1:0]    acc_q;
	crs_pkg::smp_item_t      hold_q, out_q;
	logic                    hold_valid_q, out_valid_q;

	logic                    out_free, out_load, div_start, div_done;
	logic [crs_pkg::DIV_N_W-1:0] div_n;
	logic [crs_pkg::DIV_Q_W-1:0] div_q;
	logic [LW-1:0]           s_next;
	logic [LW+3:0]           rem_try, root_try;
	logic                    sq_ge;
	logic [TW-1:0]           total;
	logic                    skip_seg;
	logic                    last_k;
	logic [crs_pkg::DIV_N_W-1:0] mag;
	crs_pkg::smp_item_t      new_smp;

	function automatic logic [WW-1:0] rnd_w(logic [51:0] v);
		logic [51:0] r;
		r = v + 52'h0_0000_8000_0000;
		return r[32 +: WW];
	endfunction

	assign out_free  = !out_valid_q || !smp_stall;
	assign smp_valid = out_valid_q;
	assign smp       = out_q;

	assign s_next  = LW'(ph_seg_q) + LW'({k_q, COORD_FRAC_BITS'(0)});
	assign last_k  = (k_q == KW'(keep_q - 1'b1));
	assign rem_try = {rem_q, sv_q[crs_pkg::SQ_W-1 -: 2]};
	assign root_try = {2'b00, root_q, 2'b01};
	assign sq_ge   = (rem_try >= root_try);
	assign skip_seg = ({1'b0, root_q} <= (LW+1)'(phase_q));
	assign total   = TW'((TW'(root_q) - TW'(phase_q) + TW'(UNIT - 1)) >> COORD_FRAC_BITS);
	assign mag     = prod_q[DW+LW] ? crs_pkg::DIV_N_W'(-prod_q) : crs_pkg::DIV_N_W'(prod_q);

	always_comb begin
		new_smp.sx = v_q[0];
		new_smp.sy = v_q[1];
		new_smp.sz = v_q[2];
		new_smp.run_end = 1'b0;
		new_smp.clipped = clip_q && last_k;
	end

	always_comb begin
		if (state_q == crs_pkg::B_SAMPLE) begin
			div_n = {5'd0, s_next, 16'd0};
		end else begin
			div_n = mag + crs_pkg::DIV_N_W'(len_q >> 1);
		end
	end

	crs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			crs_pkg::B_IDLE: if (!q_empty) state_d = crs_pkg::B_LOAD;
			crs_pkg::B_LOAD: state_d = crs_pkg::B_SQ;
			crs_pkg::B_SQ: if (ax_q == 2'd2) state_d = crs_pkg::B_SQRT;
			crs_pkg::B_SQRT:
				if (it_q == crs_pkg::DIV_C_W'(crs_pkg::SQRT_STEPS - 1)) state_d = crs_pkg::B_PLAN;
			crs_pkg::B_PLAN: state_d = skip_seg ? crs_pkg::B_NEXT : crs_pkg::B_SAMPLE;
			crs_pkg::B_SAMPLE: state_d = seg_curved_q ? crs_pkg::B_TDIV : crs_pkg::B_SMUL;
			crs_pkg::B_SMUL: state_d = crs_pkg::B_SDIVGO;
			crs_pkg::B_SDIVGO: state_d = crs_pkg::B_SDIV;
			crs_pkg::B_SDIV: if (div_done) state_d = crs_pkg::B_SFIN;
			crs_pkg::B_SFIN: state_d = (ax_q == 2'd2) ? crs_pkg::B_EMIT : crs_pkg::B_SMUL;
			crs_pkg::B_TDIV: if (div_done) state_d = crs_pkg::B_WMUL;
			crs_pkg::B_WMUL: if (m_q == 3'd4) state_d = crs_pkg::B_WSUM;
			crs_pkg::B_WSUM: state_d = crs_pkg::B_MAC;
			crs_pkg::B_MAC: if (j_q == 2'd3) state_d = crs_pkg::B_CSAT;
			crs_pkg::B_CSAT: state_d = (ax_q == 2'd2) ? crs_pkg::B_EMIT : crs_pkg::B_MAC;
			crs_pkg::B_EMIT:
				if (!hold_valid_q || out_free) begin
					state_d = last_k ? crs_pkg::B_NEXT : crs_pkg::B_SAMPLE;
				end
			crs_pkg::B_NEXT:
				state_d = (seg_curved_q && cmd_q.straight) ? crs_pkg::B_LOAD : crs_pkg::B_FLUSH;
			crs_pkg::B_FLUSH: if (!hold_valid_q || out_free) state_d = crs_pkg::B_IDLE;
			default: state_d = crs_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			crs_pkg::B_IDLE: q_pop = !q_empty;
			crs_pkg::B_SAMPLE: div_start = seg_curved_q;
			crs_pkg::B_SDIVGO: div_start = 1'b1;
			crs_pkg::B_EMIT: out_load = hold_valid_q && out_free;
			crs_pkg::B_FLUSH: out_load = hold_valid_q && out_free;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crs_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {hold_q.sx, hold_q.sy, hold_q.sz, state_q == crs_pkg::B_FLUSH,
				hold_q.clipped};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
			phase_q <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && smp_stall);
			if (state_q == crs_pkg::B_EMIT && (!hold_valid_q || out_free)) begin
				hold_valid_q <= 1'b1;
			end else if (state_q == crs_pkg::B_FLUSH && out_load) begin
				hold_valid_q <= 1'b0;
			end
			if (state_q == crs_pkg::B_PLAN) begin
				if (skip_seg) begin
					phase_q <= PW'(phase_q - PW'(root_q));
				end else begin
					phase_q <= PW'((TW + 1)'(phase_q) + (TW + 1)'(total << COORD_FRAC_BITS)
						- (TW + 1)'(root_q));
				end
			end else if (state_q == crs_pkg::B_FLUSH && state_d == crs_pkg::B_IDLE
				&& cmd_q.fin) begin
				phase_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			crs_pkg::B_IDLE: begin
				cmd_q <= q_head;
				seg_curved_q <= q_head.curved;
			end
			crs_pkg::B_LOAD: begin
				a_q <= seg_curved_q ? cmd_q.p1 : cmd_q.p2;
				if (seg_curved_q) begin
					d_q[0] <= DW'(cmd_q.p2.x) - DW'(cmd_q.p1.x);
					d_q[1] <= DW'(cmd_q.p2.y) - DW'(cmd_q.p1.y);
					d_q[2] <= DW'(cmd_q.p2.z) - DW'(cmd_q.p1.z);
				end else begin
					d_q[0] <= DW'(cmd_q.p3.x) - DW'(cmd_q.p2.x);
					d_q[1] <= DW'(cmd_q.p3.y) - DW'(cmd_q.p2.y);
					d_q[2] <= DW'(cmd_q.p3.z) - DW'(cmd_q.p2.z);
				end
				sv_q <= '0;
				rem_q <= '0;
				root_q <= '0;
				it_q <= '0;
				ax_q <= 2'd0;
			end
			crs_pkg::B_SQ: begin
				sv_q <= sv_q + crs_pkg::SQ_W'(d_q[ax_q] * d_q[ax_q]);
				ax_q <= ax_q + 2'd1;
			end
			crs_pkg::B_SQRT: begin
				sv_q <= {sv_q[crs_pkg::SQ_W-3:0], 2'b00};
				rem_q <= sq_ge ? (LW+2)'(rem_try - root_try) : (LW+2)'(rem_try);
				root_q <= {root_q[LW-2:0], sq_ge};
				it_q <= it_q + 1'b1;
			end
			crs_pkg::B_PLAN: begin
				len_q <= root_q;
				ph_seg_q <= phase_q;
				k_q <= '0;
				clip_q <= (total > TW'(MAX_SEG_SAMPLES));
				keep_q <= (total > TW'(MAX_SEG_SAMPLES)) ? KW'(MAX_SEG_SAMPLES) : KW'(total);
			end
			crs_pkg::B_SAMPLE: begin
				s_q <= s_next;
				ax_q <= 2'd0;
				j_q <= 2'd0;
				m_q <= 3'd0;
				acc_q <= '0;
			end
			crs_pkg::B_SMUL: begin
				prod_q <= d_q[ax_q] * $signed({1'b0, s_q});
			end
			crs_pkg::B_SFIN: begin
				if (prod_q[DW+LW]) begin
					v_q[ax_q] <= CW'(crs_pkg::pick_axis(a_q, ax_q) - $signed(CW'(div_q)));
				end else begin
					v_q[ax_q] <= CW'(crs_pkg::pick_axis(a_q, ax_q) + $signed(CW'(div_q)));
				end
				ax_q <= ax_q + 2'd1;
			end
			crs_pkg::B_TDIV: begin
				if (div_done) begin
					t_q <= div_q[crs_pkg::T_W-1:0];
					r_q <= (crs_pkg::T_W+1)'(1 << crs_pkg::T_W)
						- (crs_pkg::T_W+1)'(div_q[crs_pkg::T_W-1:0]);
				end
			end
			crs_pkg::B_WMUL: begin
				case (m_q)
					3'd0: t2_q <= 32'(t_q * t_q);
					3'd1: t3_q <= 48'(t2_q * t_q);
					3'd2: r2_q <= 34'(r_q * r_q);
					3'd3: wa_q <= rnd_w(52'(t_q * r2_q));
					default: wb_q <= rnd_w(52'(t2_q * r_q));
				endcase
				m_q <= m_q + 3'd1;
			end
			crs_pkg::B_WSUM: begin
				w1_q <= rnd_w((52'd1 << 49) + 52'(t3_q) + {3'd0, t3_q, 1'b0}
					- {4'd0, t2_q, 16'd0} - {2'd0, t2_q, 18'd0});
				w2_q <= rnd_w({4'd0, t_q, 32'd0} + {2'd0, t2_q, 18'd0}
					- 52'(t3_q) - {3'd0, t3_q, 1'b0});
			end
			crs_pkg::B_MAC: begin
				case (j_q)
					2'd0: acc_q <= acc_q - AW'($signed({1'b0, wa_q})
						* crs_pkg::pick_axis(cmd_q.p0, ax_q));
					2'd1: acc_q <= acc_q + AW'($signed({1'b0, w1_q})
						* crs_pkg::pick_axis(cmd_q.p1, ax_q));
					2'd2: acc_q <= acc_q + AW'($signed({1'b0, w2_q})
						* crs_pkg::pick_axis(cmd_q.p2, ax_q));
					default: acc_q <= acc_q - AW'($signed({1'b0, wb_q})
						* crs_pkg::pick_axis(cmd_q.p3, ax_q));
				endcase
				j_q <= j_q + 2'd1;
			end
			crs_pkg::B_CSAT: begin
				logic signed [AW:0] rs;
				logic signed [AW:0] sh;
				rs = (AW+1)'(acc_q) + (AW+1)'(65536);
				sh = rs >>> 17;
				if (sh > (AW+1)'(524287)) begin
					v_q[ax_q] <= CW'(524287);
				end else if (sh < -(AW+1)'(524288)) begin
					v_q[ax_q] <= CW'(-524288);
				end else begin
					v_q[ax_q] <= CW'(sh);
				end
				acc_q <= '0;
				ax_q <= ax_q + 2'd1;
			end
			crs_pkg::B_EMIT: begin
				if (!hold_valid_q || out_free) begin
					hold_q <= new_smp;
					k_q <= k_q + 1'b1;
				end
			end
			crs_pkg::B_NEXT: begin
				seg_curved_q <= 1'b0;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

// File: rtl/catmull_rom_curve_sampler_top.sv
// Flow: a segment's setup is a queue pop, a load, three squares, a 21-step square root
// and a planning step; each straight sample then takes three divisions, one per axis, and
// each curved sample one division, five weight products and twelve multiply-accumulates,
// before the sample passes through a hold register into the output register.
// The back end runs one segment at a time, and a two-entry command queue lets the front
// take points meanwhile.
// Reset clears the point history, the step phase, the queue and the output valid flags.
module catmull_rom_curve_sampler_top #(
	parameter int MAX_SEG_SAMPLES = 32,
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  crs_pkg::pt_item_t  pt,
	output logic               smp_valid,
	input  logic               smp_stall,
	output crs_pkg::smp_item_t smp
);

	logic          q_full, q_push, q_empty, q_pop;
	crs_pkg::cmd_t q_entry, q_head;

	crs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.pt       (pt),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	crs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_entry),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_head)
	);

	crs_back #(
		.MAX_SEG_SAMPLES (MAX_SEG_SAMPLES),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

endmodule
